// ----- rtl/i2p_pkg.sv -----
// Shared types, character codes and classification functions for the infix to postfix converter.
`default_nettype none

package i2p_pkg;

	// Command kinds passed from the front end to the stack engine.
	localparam logic [2:0] KIND_OPERAND = 3'd0;
	localparam logic [2:0] KIND_OPEN    = 3'd1;
	localparam logic [2:0] KIND_CLOSE   = 3'd2;
	localparam logic [2:0] KIND_OPER    = 3'd3;
	localparam logic [2:0] KIND_END     = 3'd4;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;

	localparam int QUEUE_DEPTH = 4;
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] prec;
		logic [7:0] ch;
	} cmd_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		if (c == CH_PLUS || c == CH_MINUS) begin
			p = 2'd1;
		end else if (c == CH_STAR || c == CH_SLASH) begin
			p = 2'd2;
		end else begin
			p = 2'd0;
		end
		return p;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_Z) ||
			(c >= CH_LA && c <= CH_LZ);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/i2p_front.sv -----
// Front end: accepts input items and classifies each character into a stack command.
`default_nettype none

module i2p_front (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,   // [7:0] char_in
	input  wire logic          s_tlast,   // end_expr
	input  wire logic          q_full,
	output logic               q_wr,
	output i2p_pkg::cmd_t      q_wdata
);
	import i2p_pkg::*;

	assign s_tready = !q_full;
	assign q_wr     = s_tvalid && !q_full;

	always_comb begin
		q_wdata.ch   = s_tdata;
		q_wdata.prec = prec_of(s_tdata);
		if (s_tlast) begin
			q_wdata.kind = KIND_END;
		end else if (is_alnum(s_tdata)) begin
			q_wdata.kind = KIND_OPERAND;
		end else if (s_tdata == CH_OPEN) begin
			q_wdata.kind = KIND_OPEN;
		end else if (s_tdata == CH_CLOSE) begin
			q_wdata.kind = KIND_CLOSE;
		end else begin
			q_wdata.kind = KIND_OPER;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/i2p_queue.sv -----
// Short command queue between the front end and the stack engine.
`default_nettype none

module i2p_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire i2p_pkg::cmd_t wr_data,
	output logic               full,
	input  wire logic          rd_en,
	output i2p_pkg::cmd_t      rd_data,
	output logic               empty
);
	import i2p_pkg::*;

	cmd_t           entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = count_q == QCW'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QUEUE_DEPTH))
		else $error("command queue count beyond its depth");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + QCW'(1)))
		else $error("command queue lost a write");

endmodule

`default_nettype wire

// ----- rtl/i2p_back.sv -----
// Stack engine: runs commands against the operator stack and drives the output register.
`default_nettype none

module i2p_back #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire i2p_pkg::cmd_t head,
	output logic               deq,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         m_tdata,   // [7:0] char_out
	output logic               m_tuser,   // has_char
	output logic               m_tlast    // last_out
);
	import i2p_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [7:0]    stack_mem [STACK_DEPTH];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [CW-1:0] rd_addr;
	logic [7:0]    top_q;     // mirrors the entry at cnt_q - 1
	logic [7:0]    below_q;   // mirrors the entry at cnt_q - 2

	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;
	logic          m_tuser_q;
	logic          m_tlast_q;

	logic          can_emit;
	logic          has_top;
	logic          one_left;
	logic [1:0]    top_prec;
	logic [1:0]    below_prec;
	logic          do_pop;
	logic          do_push;
	logic          push_ok;
	logic          emit;
	logic [7:0]    emit_ch;
	logic          emit_has;
	logic          emit_last;

	assign can_emit   = !m_tvalid_q || m_tready;
	assign has_top    = cnt_q != '0;
	assign one_left   = cnt_q == CW'(1);
	assign top_prec   = prec_of(top_q);
	assign below_prec = prec_of(below_q);

	always_comb begin
		deq       = 1'b0;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		emit      = 1'b0;
		emit_ch   = top_q;
		emit_has  = 1'b1;
		emit_last = 1'b0;
		if (head_valid) begin
			case (head.kind)
				KIND_OPERAND: begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_ch   = head.ch;
						emit_last = 1'b1;
						deq       = 1'b1;
					end
				end
				KIND_OPEN: begin
					do_push = 1'b1;
					deq     = 1'b1;
				end
				KIND_CLOSE: begin
					if (!has_top) begin
						deq = 1'b1;
					end else if (top_q != CH_OPEN) begin
						if (can_emit) begin
							emit      = 1'b1;
							do_pop    = 1'b1;
							emit_last = one_left || below_q == CH_OPEN;
						end
					end else begin
						// The matching open parenthesis is dropped without output.
						do_pop = 1'b1;
						deq    = 1'b1;
					end
				end
				KIND_OPER: begin
					if (has_top && top_prec >= head.prec) begin
						if (can_emit) begin
							emit      = 1'b1;
							do_pop    = 1'b1;
							emit_last = one_left || below_prec < head.prec;
						end
					end else begin
						do_push = 1'b1;
						deq     = 1'b1;
					end
				end
				KIND_END: begin
					if (can_emit) begin
						emit = 1'b1;
						if (has_top) begin
							do_pop = 1'b1;
						end else begin
							emit_ch   = '0;
							emit_has  = 1'b0;
							emit_last = 1'b1;
							deq       = 1'b1;
						end
					end
				end
				default: begin
					deq = 1'b1;
				end
			endcase
		end
	end

	// A push onto a full stack is dropped.
	assign push_ok = do_push && cnt_q < CW'(STACK_DEPTH);

	always_comb begin
		if (push_ok) begin
			cnt_d = cnt_q + CW'(1);
		end else if (do_pop) begin
			cnt_d = cnt_q - CW'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	assign rd_addr = cnt_d - CW'(2);

	// The second entry from the top is read ahead whenever two or more entries remain so that pops run back to back.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			stack_mem[cnt_q[AW-1:0]] <= head.ch;
		end
		if (cnt_d >= CW'(2)) begin
			below_q <= stack_mem[rd_addr[AW-1:0]];
		end
		if (push_ok) begin
			top_q <= head.ch;
		end else if (do_pop) begin
			top_q <= below_q;
		end
		if (emit) begin
			m_tdata_q <= emit_ch;
			m_tuser_q <= emit_has;
			m_tlast_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond the stack depth");

	a_term_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !emit_has) |=> (cnt_q == '0 && m_tvalid && m_tlast))
		else $error("terminator sent with a nonempty stack");

	a_operand_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head.kind == KIND_OPERAND && !deq) |-> (m_tvalid_q && !m_tready))
		else $error("operand held without output backpressure");

endmodule

`default_nettype wire

// ----- rtl/infix_to_postfix_converter.sv -----
// An accepted item is queued first; its first result then goes to the output register.
// Each popped char is a result of its own, sent before the popping command is dequeued.
// A four-entry command queue lets the input run ahead while the stack engine drains pops.
// The stack engine emits at most one result per cycle through a single output register.
// Reset clears the queue pointers, the stack count and the output valid; stack contents stay.
`default_nettype none

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_in
	input  wire logic       s_tlast,   // end_expr
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] char_out
	output logic            m_tuser,   // has_char
	output logic            m_tlast    // last_out
);
	import i2p_pkg::*;

	logic q_wr;
	logic q_full;
	logic q_empty;
	logic deq;
	cmd_t q_wdata;
	cmd_t head;

	i2p_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_wdata  (q_wdata)
	);

	i2p_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (deq),
		.rd_data (head),
		.empty   (q_empty)
	);

	i2p_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head),
		.deq        (deq),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire
